[rtl/eg_pkg.sv]
// ----------------------------------------------------------------------------
// eg_pkg: shared constants and types for the ECEF to geodetic converter
// Fixed-point formats, ellipsoid codes, unit start strobes, arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package eg_pkg;

    localparam int MAX_PASSES = 11;
    localparam int ANGLE_BITS = 32;
    localparam int COORD_BITS = 38;
    localparam int FRAC       = 60 - COORD_BITS;   // length fraction bits
    localparam int ASHIFT     = 61 - ANGLE_BITS;   // Q60 angle to output LSB
    localparam int CORDIC_N   = 60;
    localparam int CNT_W      = 6;                 // pass counter width

    localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;
    localparam logic [63:0] RADIUS_MM  = 64'd6378137000;
    localparam logic [63:0] INVF_WGS84 = 64'd298257223563;
    localparam logic [63:0] INVF_CGCS  = 64'd298257222101;
    localparam logic [63:0] INVF_DEN   = 64'd1000000000;
    localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
    localparam logic [63:0] HALF_PI    = 64'h0800_0000_0000_0000;  // 2^59

    // ellipsoid codes
    localparam logic [1:0] ELL_WGS84 = 2'd0;
    localparam logic [1:0] ELL_CGCS  = 2'd1;
    localparam logic [1:0] ELL_NONE  = 2'd2;

    // register index (address bit 2)
    localparam logic REG_ELLIPSOID = 1'b0;

    // start strobes to the shared units
    typedef struct packed {
        logic mul;
        logic div;
        logic sqrt;
        logic cor;
    } t_go;

    localparam t_go GO_NONE = 4'b0000;
    localparam t_go GO_MUL  = 4'b1000;
    localparam t_go GO_DIV  = 4'b0100;
    localparam t_go GO_SQRT = 4'b0010;
    localparam t_go GO_COR  = 4'b0001;

    typedef logic [CORDIC_N-1:0][63:0] t_atab;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // atan(2^-i) in Q60 semicircles: power series in Q62 radians times 1/pi
    function automatic t_atab atan_table();
        t_atab       tab;
        logic [63:0] acc;
        logic [63:0] term;
        logic [127:0] prod;
        int          i;
        int          k;
        tab[0] = 64'd1 << 58;
        for (i = 1; i < CORDIC_N; i++) begin
            acc = 64'd0;
            for (k = 0; i * (2 * k + 1) <= 62; k++) begin
                term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if (k[0]) acc = acc - term;
                else      acc = acc + term;
            end
            prod   = {64'd0, acc} * {64'd0, INV_PI_Q64};
            tab[i] = {2'b00, prod[127:66]};
        end
        return tab;
    endfunction

    localparam t_atab ATAB = atan_table();

endpackage

`default_nettype wire

[rtl/eg_mul.sv]
// ----------------------------------------------------------------------------
// eg_mul: 64 x 64 unsigned multiplier, one 32 x 32 partial product a cycle
// Four partial products, each registered and then accumulated.
// ----------------------------------------------------------------------------
`default_nettype none

module eg_mul (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_p
);
    import eg_pkg::*;

    logic        r_busy;
    logic [2:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_pp;
    logic [1:0]  r_psh;
    logic [127:0] r_p;
    logic        r_done;
    logic [31:0] n_asel;
    logic [31:0] n_bsel;
    logic [127:0] n_ppw;

    assign n_asel = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign n_bsel = r_cnt[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (r_psh)
            2'd0:    n_ppw = {64'd0, r_pp};
            2'd1:    n_ppw = {32'd0, r_pp, 32'd0};
            default: n_ppw = {r_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_p    <= 128'd0;
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp  <= n_asel * n_bsel;
                    r_psh <= 2'({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]});
                end
                if (r_cnt != 3'd0) r_p <= r_p + n_ppw;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

`default_nettype wire

[rtl/eg_div.sv]
// ----------------------------------------------------------------------------
// eg_div: 128 / 64 restoring divider, one quotient bit a cycle
// Saturates to all ones on a zero divisor or quotient overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module eg_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_num,
    input  wire logic [63:0]  i_den,
    output logic              o_done,
    output logic [63:0]       o_q
);
    import eg_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_lo;
    logic [63:0] r_den;
    logic [63:0] r_q;
    logic [63:0] n_rem2;
    logic        n_take;

    assign n_rem2 = {r_rem[62:0], r_lo[63]};
    assign n_take = r_rem[63] || (n_rem2 >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_rem <= i_num[127:64];
                r_lo  <= i_num[63:0];
                r_q   <= '0;
                r_cnt <= '0;
                if (i_den == 64'd0 || i_num[127:64] >= i_den) begin
                    r_q    <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_lo  <= {r_lo[62:0], 1'b0};
                r_rem <= n_take ? (n_rem2 - r_den) : n_rem2;
                r_q   <= {r_q[62:0], n_take};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

`default_nettype wire

[rtl/eg_sqrt.sv]
// ----------------------------------------------------------------------------
// eg_sqrt: floor square root of a 128-bit value, one root bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module eg_sqrt (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_rad,
    output logic              o_done,
    output logic [63:0]       o_root
);
    import eg_pkg::*;

    logic         r_busy;
    logic         r_done;
    logic [5:0]   r_cnt;
    logic [127:0] r_rad;
    logic [67:0]  r_rem;
    logic [63:0]  r_root;
    logic [67:0]  n_rem2;
    logic [67:0]  n_trial;
    logic         n_take;

    assign n_rem2  = {r_rem[65:0], r_rad[127:126]};
    assign n_trial = {2'b00, r_root, 2'b01};
    assign n_take  = n_rem2 >= n_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[125:0], 2'b00};
                r_rem  <= n_take ? (n_rem2 - n_trial) : n_rem2;
                r_root <= {r_root[62:0], n_take};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

[rtl/eg_cordic.sv]
// ----------------------------------------------------------------------------
// eg_cordic: vectoring CORDIC, atan2(y, x) in Q60 semicircles
// Normalizes the vector one shift a cycle, then 60 rotation steps.
// ----------------------------------------------------------------------------
`default_nettype none

module eg_cordic (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_y,
    input  wire logic [63:0] i_x,
    output logic             o_done,
    output logic [63:0]      o_angle
);
    import eg_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    logic [1:0]         r_state;
    logic               r_done;
    logic [5:0]         r_i;
    logic signed [63:0] r_vx;
    logic signed [63:0] r_vy;
    logic signed [63:0] r_z;
    logic               r_xneg;
    logic               r_yneg;
    logic [63:0]        r_angle;
    logic [63:0]        n_ux;
    logic [63:0]        n_uy;
    logic [63:0]        n_mx;
    logic signed [63:0] n_dx;
    logic signed [63:0] n_dy;
    logic [63:0]        n_clamp;
    logic [63:0]        n_refl;

    assign n_ux = mag64(i_x);
    assign n_uy = mag64(i_y);
    assign n_mx = (r_vx > r_vy) ? r_vx : r_vy;
    assign n_dx = r_vy >>> r_i;
    assign n_dy = r_vx >>> r_i;

    always_comb begin
        if (r_z < 0)                     n_clamp = 64'd0;
        else if (r_z > $signed(HALF_PI)) n_clamp = HALF_PI;
        else                             n_clamp = r_z;
        n_refl = r_xneg ? (ONE_Q60 - n_clamp) : n_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_xneg <= i_x[63];
                        r_yneg <= i_y[63];
                        r_vx   <= n_ux;
                        r_vy   <= n_uy;
                        if (n_uy == 64'd0) begin
                            r_angle <= i_x[63] ? ONE_Q60 : 64'd0;
                            r_done  <= 1'b1;
                        end else if (n_ux == 64'd0) begin
                            r_angle <= i_y[63] ? (64'd0 - HALF_PI) : HALF_PI;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (n_mx < 64'd1 << 57) begin
                        r_vx <= r_vx <<< 1;
                        r_vy <= r_vy <<< 1;
                    end else if (n_mx >= 64'd1 << 58) begin
                        r_vx <= r_vx >>> 1;
                        r_vy <= r_vy >>> 1;
                    end else begin
                        r_i     <= '0;
                        r_z     <= '0;
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (!r_vy[63]) begin
                        r_vx <= r_vx + n_dx;
                        r_vy <= r_vy - n_dy;
                        r_z  <= r_z + $signed(ATAB[r_i]);
                    end else begin
                        r_vx <= r_vx - n_dx;
                        r_vy <= r_vy + n_dy;
                        r_z  <= r_z - $signed(ATAB[r_i]);
                    end
                    r_i <= r_i + 6'd1;
                    if (r_i == 6'(CORDIC_N - 1)) r_state <= C_FIN;
                end
                default: begin
                    r_angle <= r_yneg ? (64'd0 - n_refl) : n_refl;
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

`default_nettype wire

[rtl/ecef_to_geodetic.sv]
// ----------------------------------------------------------------------------
// ecef_to_geodetic: earth-centred X, Y, Z to latitude, longitude and height
// Sequencer over a shared multiplier, divider, square root and CORDIC.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block takes an item only when idle and
// holds its result in an output register until taken; it then accepts the
// next item. An item runs a setup (ellipsoid terms, longitude, horizontal
// range, first latitude), then up to 11 latitude passes, then the height.
// The time goes into the serial units: divide, root, CORDIC angle and
// 64x64 multiply, each handed off through the sequencer's S_WAIT state. An
// origin input finishes with at_origin set and all else zero.
// Ellipsoid register at byte address 0: 0 WGS84, 1 CGCS2000, 2 or 3 none
// (geocentric latitude, height is distance from centre). Write it only while
// idle. Angles are in 2^-31 semicircle; a longitude of 180 degrees reads as
// the most negative code. Height saturates to the 38-bit signed range.
// ----------------------------------------------------------------------------
`default_nettype none

module ecef_to_geodetic (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [eg_pkg::COORD_BITS-1:0]   i_x_mm,
    input  wire logic [eg_pkg::COORD_BITS-1:0]   i_y_mm,
    input  wire logic [eg_pkg::COORD_BITS-1:0]   i_z_mm,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [eg_pkg::ANGLE_BITS-1:0]        o_latitude,
    output logic [eg_pkg::ANGLE_BITS-1:0]        o_longitude,
    output logic [eg_pkg::COORD_BITS-1:0]        o_height_mm,
    output logic                                 o_at_origin,
    output logic [3:0]                           o_passes_used,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import eg_pkg::*;

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_START = 5'd1;
    localparam logic [4:0] S_WAIT  = 5'd2;
    localparam logic [4:0] S_F     = 5'd3;
    localparam logic [4:0] S_FF    = 5'd4;
    localparam logic [4:0] S_E2    = 5'd5;
    localparam logic [4:0] S_AE2   = 5'd6;
    localparam logic [4:0] S_LON   = 5'd7;
    localparam logic [4:0] S_P1    = 5'd8;
    localparam logic [4:0] S_P2    = 5'd9;
    localparam logic [4:0] S_P3    = 5'd10;
    localparam logic [4:0] S_B0    = 5'd11;
    localparam logic [4:0] S_R1    = 5'd12;
    localparam logic [4:0] S_R2    = 5'd13;
    localparam logic [4:0] S_R3    = 5'd14;
    localparam logic [4:0] S_R4    = 5'd15;
    localparam logic [4:0] S_C1    = 5'd16;
    localparam logic [4:0] S_C2    = 5'd17;
    localparam logic [4:0] S_NB    = 5'd18;
    localparam logic [4:0] S_M1    = 5'd19;
    localparam logic [4:0] S_M2    = 5'd20;
    localparam logic [4:0] S_M3    = 5'd21;
    localparam logic [4:0] S_T1    = 5'd22;
    localparam logic [4:0] S_T2A   = 5'd23;
    localparam logic [4:0] S_T2B   = 5'd24;
    localparam logic [4:0] S_T3A   = 5'd25;
    localparam logic [4:0] S_T3B   = 5'd26;
    localparam logic [4:0] S_H     = 5'd27;
    localparam logic [4:0] S_OUT   = 5'd28;

    localparam int HQ_W = 64 - FRAC;   // height after rounding, before saturation

    logic [4:0]   r_state;
    logic [4:0]   r_ret;
    t_go          r_go;
    logic [63:0]  r_opa;
    logic [63:0]  r_opb;
    logic [127:0] r_opn;
    logic [127:0] r_res;
    logic [1:0]   r_ell;

    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [COORD_BITS-1:0] r_z;
    logic [63:0]  r_f;
    logic [63:0]  r_c1;
    logic [63:0]  r_af;
    logic [63:0]  r_ae2;
    logic [63:0]  r_lon;
    logic [63:0]  r_b;
    logic [63:0]  r_p;
    logic [63:0]  r_zf;
    logic [63:0]  r_t;
    logic [63:0]  r_tm;
    logic [63:0]  r_u;
    logic [63:0]  r_s;
    logic [63:0]  r_m;
    logic [63:0]  r_t1;
    logic [63:0]  r_t2;
    logic [63:0]  r_h;
    logic [127:0] r_acc;
    logic [CNT_W-1:0] r_n;
    logic         r_final;

    logic [ANGLE_BITS-1:0] r_olat;
    logic [ANGLE_BITS-1:0] r_olon;
    logic [COORD_BITS-1:0] r_oh;
    logic         r_oorg;
    logic [3:0]   r_opass;

    // unit interfaces
    logic         mul_done;
    logic [127:0] mul_p;
    logic         div_done;
    logic [63:0]  div_q;
    logic         sqrt_done;
    logic [63:0]  sqrt_root;
    logic         cor_done;
    logic [63:0]  cor_angle;

    // next-value helpers
    logic [63:0]  n_xe;
    logic [63:0]  n_ye;
    logic [63:0]  n_ze;
    logic [63:0]  n_e2;
    logic [63:0]  n_tm;
    logic [127:0] n_sum;
    logic [63:0]  n_tnew;
    logic [63:0]  n_diff;
    logic [63:0]  n_lat;
    logic [63:0]  n_lonr;
    logic [63:0]  n_hs;
    logic [HQ_W-1:0] n_hq;
    logic [COORD_BITS-1:0] n_hsat;
    logic         n_more;

    assign n_xe   = {{(64-COORD_BITS){r_x[COORD_BITS-1]}}, r_x};
    assign n_ye   = {{(64-COORD_BITS){r_y[COORD_BITS-1]}}, r_y};
    assign n_ze   = {{(64-COORD_BITS){r_z[COORD_BITS-1]}}, r_z};
    assign n_e2   = (r_f << 1) - r_res[123:60];          // 2f - f^2
    assign n_tm   = mag64(r_t);
    assign n_sum  = r_acc + r_res;
    assign n_tnew = r_zf + (r_t[63] ? (64'd0 - r_res[63:0]) : r_res[63:0]);
    assign n_diff = mag64(r_res[63:0] - r_b);
    assign n_more = (n_diff >= (64'd1 << ASHIFT)) &&
                    ((r_n + CNT_W'(1)) < CNT_W'(MAX_PASSES));

    // round half up to the output LSB
    assign n_lat  = r_b   + (64'd1 << (ASHIFT - 1));
    assign n_lonr = r_lon + (64'd1 << (ASHIFT - 1));
    assign n_hs   = r_h   + (64'd1 << (FRAC - 1));
    assign n_hq   = n_hs[63:FRAC];

    // saturate when the bits above the output sign disagree
    always_comb begin
        if (n_hq[HQ_W-1:COORD_BITS-1] == '0 || n_hq[HQ_W-1:COORD_BITS-1] == '1)
            n_hsat = n_hq[COORD_BITS-1:0];
        else if (n_hq[HQ_W-1])
            n_hsat = {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            n_hsat = {1'b0, {(COORD_BITS-1){1'b1}}};
    end

    eg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go.mul),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    eg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go.div),
        .i_num   (r_opn),
        .i_den   (r_opb),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    eg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go.sqrt),
        .i_rad   (r_opn),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    eg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go.cor),
        .i_y     (r_opa),
        .i_x     (r_opb),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    // config port: single register, no wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ELLIPSOID) ? {30'd0, r_ell} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ell <= ELL_WGS84;
        end else if (psel && penable && pwrite && paddr[2] == REG_ELLIPSOID) begin
            r_ell <= pwdata[1:0];
        end
    end

    // sequencer: most steps take the last unit result from r_res, then
    // launch the next operation and park in S_WAIT until it is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_go    <= GO_NONE;
            r_final <= 1'b0;
        end else begin
            r_go <= GO_NONE;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= i_x_mm;
                        r_y     <= i_y_mm;
                        r_z     <= i_z_mm;
                        r_final <= 1'b0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (r_x == '0 && r_y == '0 && r_z == '0) begin
                        r_olat  <= '0;
                        r_olon  <= '0;
                        r_oh    <= '0;
                        r_oorg  <= 1'b1;
                        r_opass <= '0;
                        r_state <= S_OUT;
                    end else if (r_ell == ELL_WGS84 || r_ell == ELL_CGCS) begin
                        r_opa   <= ONE_Q60;
                        r_opb   <= INVF_DEN;
                        r_go    <= GO_MUL;
                        r_ret   <= S_F;
                        r_state <= S_WAIT;
                    end else begin
                        r_c1    <= ONE_Q60;
                        r_af    <= '0;
                        r_ae2   <= '0;
                        r_opa   <= n_ye;
                        r_opb   <= n_xe;
                        r_go    <= GO_COR;
                        r_ret   <= S_LON;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (mul_done) begin
                        r_res   <= mul_p;
                        r_state <= r_ret;
                    end else if (div_done) begin
                        r_res   <= {64'd0, div_q};
                        r_state <= r_ret;
                    end else if (sqrt_done) begin
                        r_res   <= {64'd0, sqrt_root};
                        r_state <= r_ret;
                    end else if (cor_done) begin
                        r_res   <= {64'd0, cor_angle};
                        r_state <= r_ret;
                    end
                end
                // flattening f = 2^60 / (1/f)
                S_F: begin
                    r_opn   <= r_res;
                    r_opb   <= (r_ell == ELL_WGS84) ? INVF_WGS84 : INVF_CGCS;
                    r_go    <= GO_DIV;
                    r_ret   <= S_FF;
                    r_state <= S_WAIT;
                end
                S_FF: begin
                    r_f     <= r_res[63:0];
                    r_opa   <= r_res[63:0];
                    r_opb   <= r_res[63:0];
                    r_go    <= GO_MUL;
                    r_ret   <= S_E2;
                    r_state <= S_WAIT;
                end
                S_E2: begin
                    r_c1    <= ONE_Q60 - n_e2;
                    r_af    <= RADIUS_MM << FRAC;
                    r_opa   <= RADIUS_MM << FRAC;
                    r_opb   <= n_e2;
                    r_go    <= GO_MUL;
                    r_ret   <= S_AE2;
                    r_state <= S_WAIT;
                end
                S_AE2: begin
                    r_ae2   <= r_res[123:60];
                    r_opa   <= n_ye;
                    r_opb   <= n_xe;
                    r_go    <= GO_COR;
                    r_ret   <= S_LON;
                    r_state <= S_WAIT;
                end
                // longitude, then p = sqrt(x^2 + y^2)
                S_LON: begin
                    r_lon   <= r_res[63:0];
                    r_opa   <= mag64(n_xe);
                    r_opb   <= mag64(n_xe);
                    r_go    <= GO_MUL;
                    r_ret   <= S_P1;
                    r_state <= S_WAIT;
                end
                S_P1: begin
                    r_acc   <= r_res;
                    r_opa   <= mag64(n_ye);
                    r_opb   <= mag64(n_ye);
                    r_go    <= GO_MUL;
                    r_ret   <= S_P2;
                    r_state <= S_WAIT;
                end
                S_P2: begin
                    r_opn   <= n_sum << (2 * FRAC);
                    r_go    <= GO_SQRT;
                    r_ret   <= S_P3;
                    r_state <= S_WAIT;
                end
                S_P3: begin
                    r_p     <= r_res[63:0];
                    r_zf    <= n_ze << FRAC;
                    r_t     <= n_ze << FRAC;
                    r_opa   <= n_ze << FRAC;
                    r_opb   <= r_res[63:0];
                    r_go    <= GO_COR;
                    r_ret   <= S_B0;
                    r_state <= S_WAIT;
                end
                S_B0: begin
                    r_b     <= r_res[63:0];
                    r_n     <= '0;
                    r_tm    <= n_tm;
                    r_opa   <= n_tm;
                    r_opb   <= r_c1;
                    r_go    <= GO_MUL;
                    r_ret   <= S_R1;
                    r_state <= S_WAIT;
                end
                // s = sqrt(p^2 + (1 - e2) t^2)
                S_R1: begin
                    r_u     <= r_res[123:60];
                    r_opa   <= r_p;
                    r_opb   <= r_p;
                    r_go    <= GO_MUL;
                    r_ret   <= S_R2;
                    r_state <= S_WAIT;
                end
                S_R2: begin
                    r_acc   <= r_res;
                    r_opa   <= r_u;
                    r_opb   <= r_tm;
                    r_go    <= GO_MUL;
                    r_ret   <= S_R3;
                    r_state <= S_WAIT;
                end
                S_R3: begin
                    r_opn   <= n_sum;
                    r_go    <= GO_SQRT;
                    r_ret   <= S_R4;
                    r_state <= S_WAIT;
                end
                S_R4: begin
                    r_s <= r_res[63:0];
                    if (r_final) begin
                        r_opa   <= r_p;
                        r_opb   <= r_p;
                        r_go    <= GO_MUL;
                        r_ret   <= S_M1;
                        r_state <= S_WAIT;
                    end else if (r_res[63:0] != 64'd0) begin
                        r_opa   <= r_ae2;
                        r_opb   <= r_tm;
                        r_go    <= GO_MUL;
                        r_ret   <= S_C1;
                        r_state <= S_WAIT;
                    end else begin
                        // zero root: no correction term
                        r_t     <= r_zf;
                        r_opa   <= r_zf;
                        r_opb   <= r_p;
                        r_go    <= GO_COR;
                        r_ret   <= S_NB;
                        r_state <= S_WAIT;
                    end
                end
                // correction a e2 t / s, new t
                S_C1: begin
                    r_opn   <= r_res;
                    r_opb   <= r_s;
                    r_go    <= GO_DIV;
                    r_ret   <= S_C2;
                    r_state <= S_WAIT;
                end
                S_C2: begin
                    r_t     <= n_tnew;
                    r_opa   <= n_tnew;
                    r_opb   <= r_p;
                    r_go    <= GO_COR;
                    r_ret   <= S_NB;
                    r_state <= S_WAIT;
                end
                // new latitude; repeat or take the last root for the height
                S_NB: begin
                    r_b     <= r_res[63:0];
                    r_n     <= r_n + CNT_W'(1);
                    r_final <= !n_more;
                    r_tm    <= n_tm;
                    r_opa   <= n_tm;
                    r_opb   <= r_c1;
                    r_go    <= GO_MUL;
                    r_ret   <= S_R1;
                    r_state <= S_WAIT;
                end
                // m = sqrt(p^2 + t^2)
                S_M1: begin
                    r_acc   <= r_res;
                    r_opa   <= r_tm;
                    r_opb   <= r_tm;
                    r_go    <= GO_MUL;
                    r_ret   <= S_M2;
                    r_state <= S_WAIT;
                end
                S_M2: begin
                    r_opn   <= n_sum;
                    r_go    <= GO_SQRT;
                    r_ret   <= S_M3;
                    r_state <= S_WAIT;
                end
                S_M3: begin
                    r_m <= r_res[63:0];
                    if (r_res[63:0] == 64'd0) begin
                        r_h     <= '0;
                        r_state <= S_H;
                    end else begin
                        r_opn   <= r_acc;       // p^2
                        r_opb   <= r_res[63:0];
                        r_go    <= GO_DIV;
                        r_ret   <= S_T1;
                        r_state <= S_WAIT;
                    end
                end
                // h = p^2/m + zf t / m - a s / m
                S_T1: begin
                    r_t1    <= r_res[63:0];
                    r_opa   <= mag64(r_zf);
                    r_opb   <= r_tm;
                    r_go    <= GO_MUL;
                    r_ret   <= S_T2A;
                    r_state <= S_WAIT;
                end
                S_T2A: begin
                    r_opn   <= r_res;
                    r_opb   <= r_m;
                    r_go    <= GO_DIV;
                    r_ret   <= S_T2B;
                    r_state <= S_WAIT;
                end
                S_T2B: begin
                    r_t2    <= (r_zf[63] != r_t[63]) ? (64'd0 - r_res[63:0]) : r_res[63:0];
                    r_opa   <= r_af;
                    r_opb   <= r_s;
                    r_go    <= GO_MUL;
                    r_ret   <= S_T3A;
                    r_state <= S_WAIT;
                end
                S_T3A: begin
                    r_opn   <= r_res;
                    r_opb   <= r_m;
                    r_go    <= GO_DIV;
                    r_ret   <= S_T3B;
                    r_state <= S_WAIT;
                end
                S_T3B: begin
                    r_h     <= r_t1 + r_t2 - r_res[63:0];
                    r_state <= S_H;
                end
                S_H: begin
                    r_olat  <= n_lat[ASHIFT+ANGLE_BITS-1:ASHIFT];
                    r_olon  <= n_lonr[ASHIFT+ANGLE_BITS-1:ASHIFT];
                    r_oh    <= n_hsat;
                    r_oorg  <= 1'b0;
                    r_opass <= r_n[3:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_latitude    = r_olat;
    assign o_longitude   = r_olon;
    assign o_height_mm   = r_oh;
    assign o_at_origin   = r_oorg;
    assign o_passes_used = r_opass;

endmodule

`default_nettype wire

[rtl/eg_checker.sv]
// ----------------------------------------------------------------------------
// eg_checker: port-level checks for the ECEF to geodetic converter
// Bound to the top level; watches the result beat and the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module eg_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            o_ready,
    input  wire logic                            o_valid,
    input  wire logic                            i_ready,
    input  wire logic [eg_pkg::ANGLE_BITS-1:0]   o_latitude,
    input  wire logic [eg_pkg::ANGLE_BITS-1:0]   o_longitude,
    input  wire logic [eg_pkg::COORD_BITS-1:0]   o_height_mm,
    input  wire logic                            o_at_origin,
    input  wire logic [3:0]                      o_passes_used
);
    import eg_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_latitude) &&
        $stable(o_longitude) && $stable(o_height_mm) && $stable(o_passes_used))
        else $error("result beat changed while stalled");

    // one item at a time: no input taken while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    // origin result carries nothing but the flag
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_at_origin |-> o_latitude == '0 && o_longitude == '0 &&
        o_height_mm == '0 && o_passes_used == '0)
        else $error("origin result not clear");

    // pass count within bounds for a normal result
    a_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_at_origin |-> o_passes_used != 4'd0 &&
        o_passes_used <= 4'(MAX_PASSES))
        else $error("pass count out of range");

    // latitude never beyond the poles
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $signed(o_latitude) <= $signed(32'sd1073741824) &&
        $signed(o_latitude) >= $signed(-32'sd1073741824))
        else $error("latitude beyond pole");

endmodule

bind ecef_to_geodetic eg_checker u_eg_checker (.*);

`default_nettype wire
